// ----- sv/bsfa_pkg.sv -----
// Shared types, widths, register indexes and constant tables for the battery
// charge estimator. Depends on nothing; every other file imports it.
package bsfa_pkg;

    localparam int ADC_BITS       = 12;
    localparam int MAX_THRESHOLDS = 8;
    localparam int THR_IDX_W      = $clog2(MAX_THRESHOLDS);
    localparam int MV_W           = 16;
    localparam int PCT_W          = 7;
    localparam int VOLTS_W        = 7;
    localparam int MICRO_W        = 20;
    localparam int FS_W           = 16;
    localparam int OHM_W          = 24;
    localparam int THR_CNT_W      = 4;
    localparam int WORD_W         = 64;
    localparam int CFG_IDX_W      = 3;

    // Shared shift-add multiplier and restoring divider.
    localparam int MCAND_W   = 24;
    localparam int MPLIER_W  = 16;
    localparam int PROD_W    = MCAND_W + MPLIER_W;
    localparam int DIVISOR_W = 24;
    localparam int QUO_W     = PROD_W - DIVISOR_W;

    localparam int KV_REM_W = 10;

    localparam logic [MV_W-1:0]  MV_MAX   = {MV_W{1'b1}};
    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_NONE = '0;
    localparam int               MV_PER_V = 1000;

    localparam logic [FS_W-1:0]      FS_RESET      = FS_W'(3600);
    localparam logic [OHM_W-1:0]     OHM_RESET     = OHM_W'(1);
    localparam logic [THR_CNT_W-1:0] THR_CNT_RESET = THR_CNT_W'(2);
    localparam logic [WORD_W-1:0]    THR_LO_RESET  = WORD_W'(275254500);
    localparam logic [WORD_W-1:0]    THR_HI_RESET  = '0;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OHM    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FULL_OHM   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_THR_COUNT  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_THR_LO     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_THR_HI     = CFG_IDX_W'(5);

    // Percent at breakpoint i for a table whose last index is L, i*100/L.
    // Indexed by {L, i}; entries beyond L are never read.
    localparam logic [PCT_W-1:0] PCT_POINTS [64] = '{
        7'd0, 7'd0,   7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
        7'd0, 7'd100, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
        7'd0, 7'd50,  7'd100, 7'd0, 7'd0,  7'd0,  7'd0,  7'd0,
        7'd0, 7'd33,  7'd66, 7'd100, 7'd0, 7'd0,  7'd0,  7'd0,
        7'd0, 7'd25,  7'd50, 7'd75, 7'd100, 7'd0, 7'd0,  7'd0,
        7'd0, 7'd20,  7'd40, 7'd60, 7'd80, 7'd100, 7'd0, 7'd0,
        7'd0, 7'd16,  7'd33, 7'd50, 7'd66, 7'd83, 7'd100, 7'd0,
        7'd0, 7'd14,  7'd28, 7'd42, 7'd57, 7'd71, 7'd85, 7'd100
    };

    typedef struct packed {
        logic [ADC_BITS-1:0] adc_sample;
        logic                read_ok;
    } in_word_t;

    typedef struct packed {
        logic [MV_W-1:0]    battery_mv;
        logic [PCT_W-1:0]   charge_percent;
        logic [VOLTS_W-1:0] volts_whole;
        logic [MICRO_W-1:0] volts_micro;
        logic               read_failed;
    } out_word_t;

    function automatic logic [MV_W-1:0] thr_at(
        input logic [WORD_W-1:0]    lo_word,
        input logic [WORD_W-1:0]    hi_word,
        input logic [THR_IDX_W-1:0] idx
    );
        logic [WORD_W-1:0] word;
        word = idx[THR_IDX_W-1] ? hi_word : lo_word;
        return word[{idx[THR_IDX_W-2:0], 4'b0000} +: MV_W];
    endfunction

endpackage

// ----- sv/bsfa_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on bsfa_pkg for operand and product widths.
module bsfa_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bsfa_pkg::MCAND_W-1:0]  mcand,
    input  logic [bsfa_pkg::MPLIER_W-1:0] mplier,
    output logic                          done,
    output logic [bsfa_pkg::PROD_W-1:0]   product
);
    import bsfa_pkg::*;

    localparam int STEP_W = $clog2(MPLIER_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [MCAND_W-1:0]  mcand_reg, mcand_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [MCAND_W:0]    sum;

    always_comb
    begin
        // Upper half accumulates; the multiplier drains out of the lower half.
        if (prod_reg[0])
        begin
            sum = {1'b0, prod_reg[PROD_W-1:MPLIER_W]} + {1'b0, mcand_reg};
        end
        else
        begin
            sum = {1'b0, prod_reg[PROD_W-1:MPLIER_W]};
        end

        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            mcand_next = mcand;
            prod_next  = {{MCAND_W{1'b0}}, mplier};
        end
        else if (busy_reg)
        begin
            prod_next = {sum, prod_reg[MPLIER_W-1:1]};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(MPLIER_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// ----- sv/bsfa_div.sv -----
// Restoring divider, one quotient bit per cycle. The upper part of the
// dividend must be below the divisor. Depends on bsfa_pkg for widths.
module bsfa_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bsfa_pkg::PROD_W-1:0]    dividend,
    input  logic [bsfa_pkg::DIVISOR_W-1:0] divisor,
    output logic                           done,
    output logic [bsfa_pkg::QUO_W-1:0]     quotient,
    output logic [bsfa_pkg::DIVISOR_W-1:0] remainder
);
    import bsfa_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W+1:0] trial;
    logic                 fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[QUO_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = !trial[DIVISOR_W+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvs_next  = divisor;
            rem_next  = dividend[PROD_W-1:QUO_W];
            quo_next  = dividend[QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/battery_soc_from_adc.sv -----
// Top level of the battery voltage and charge estimator: configuration
// registers, sequencer, threshold search and output register.
// Depends on bsfa_pkg, bsfa_mul and bsfa_div.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   input    | in_valid / in_ready  | in_data (in_word_t)
//   result   | out_valid / out_ready| out_data (out_word_t)
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data (64 bits)
//
// Each multiply and divide is one pass of a bit-serial unit, with its start and
// done. A good read takes up to six passes, a threshold search and three
// single-step states; a failed read takes one pass.
// in_ready is high only while the sequencer is idle; a finished word waits in
// the output register, so the next word is taken while it stalls.
// Reset restores the documented register values and clears the held values.
module battery_soc_from_adc (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bsfa_pkg::in_word_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bsfa_pkg::out_word_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsfa_pkg::WORD_W-1:0]     cfg_data
);
    import bsfa_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MUL_PIN   = 4'd1;
    localparam logic [3:0] ST_MUL_SCALE = 4'd2;
    localparam logic [3:0] ST_DIV_MV    = 4'd3;
    localparam logic [3:0] ST_PCT_CHK   = 4'd4;
    localparam logic [3:0] ST_PCT_SRCH  = 4'd5;
    localparam logic [3:0] ST_MUL_PCT   = 4'd6;
    localparam logic [3:0] ST_DIV_PCT   = 4'd7;
    localparam logic [3:0] ST_DIV_KV    = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [FS_W-1:0]      full_scale_reg, full_scale_next;
    logic [OHM_W-1:0]     out_ohm_reg, out_ohm_next;
    logic [OHM_W-1:0]     full_ohm_reg, full_ohm_next;
    logic [THR_CNT_W-1:0] thr_count_reg, thr_count_next;
    logic [WORD_W-1:0]    thr_lo_reg, thr_lo_next;
    logic [WORD_W-1:0]    thr_hi_reg, thr_hi_next;
    logic [MV_W-1:0]      held_mv_reg, held_mv_next;
    logic [PCT_W-1:0]     held_pct_reg, held_pct_next;
    logic                 failed_reg, failed_next;
    logic [THR_IDX_W-1:0] idx_reg, idx_next;
    logic [PCT_W-1:0]     lo_pct_reg, lo_pct_next;
    logic [MV_W-1:0]      width_reg, width_next;
    logic                 mul_start_reg, mul_start_next;
    logic [MCAND_W-1:0]   mul_mcand_reg, mul_mcand_next;
    logic [MPLIER_W-1:0]  mul_mplier_reg, mul_mplier_next;
    logic                 div_start_reg, div_start_next;
    logic [PROD_W-1:0]    div_dividend_reg, div_dividend_next;
    logic [DIVISOR_W-1:0] div_divisor_reg, div_divisor_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_data_reg, out_data_next;

    logic                 mul_done;
    logic [PROD_W-1:0]    mul_product;
    logic                 div_done;
    logic [QUO_W-1:0]     div_quotient;
    logic [DIVISOR_W-1:0] div_remainder;

    logic [THR_IDX_W-1:0] last_idx;
    logic [THR_IDX_W-1:0] prev_idx;
    logic [MV_W-1:0]      thr_first;
    logic [MV_W-1:0]      thr_last;
    logic [MV_W-1:0]      thr_cur;
    logic [MV_W-1:0]      thr_prev;
    logic [PCT_W-1:0]     pct_hi;
    logic [PCT_W-1:0]     pct_lo;
    logic [KV_REM_W-1:0]  kv_rem;
    logic [MICRO_W-1:0]   kv_rem_w;
    logic                 kv_start;

    bsfa_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .mcand   (mul_mcand_reg),
        .mplier  (mul_mplier_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    bsfa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_dividend_reg),
        .divisor   (div_divisor_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_comb
    begin
        // A count of zero acts as one threshold; large counts clamp to the table.
        if (thr_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (thr_count_reg > THR_CNT_W'(MAX_THRESHOLDS))
        begin
            last_idx = THR_IDX_W'(MAX_THRESHOLDS - 1);
        end
        else
        begin
            last_idx = THR_IDX_W'(thr_count_reg - 1'b1);
        end

        prev_idx  = idx_reg - 1'b1;
        thr_first = thr_at(thr_lo_reg, thr_hi_reg, '0);
        thr_last  = thr_at(thr_lo_reg, thr_hi_reg, last_idx);
        thr_cur   = thr_at(thr_lo_reg, thr_hi_reg, idx_reg);
        thr_prev  = thr_at(thr_lo_reg, thr_hi_reg, prev_idx);
        pct_hi    = PCT_POINTS[{last_idx, idx_reg}];
        pct_lo    = PCT_POINTS[{last_idx, prev_idx}];

        // Remainder times 1000 as 1024 - 16 - 8.
        kv_rem   = div_remainder[KV_REM_W-1:0];
        kv_rem_w = MICRO_W'(kv_rem);
    end

    always_comb
    begin
        state_next        = state_reg;
        full_scale_next   = full_scale_reg;
        out_ohm_next      = out_ohm_reg;
        full_ohm_next     = full_ohm_reg;
        thr_count_next    = thr_count_reg;
        thr_lo_next       = thr_lo_reg;
        thr_hi_next       = thr_hi_reg;
        held_mv_next      = held_mv_reg;
        held_pct_next     = held_pct_reg;
        failed_next       = failed_reg;
        idx_next          = idx_reg;
        lo_pct_next       = lo_pct_reg;
        width_next        = width_reg;
        mul_start_next    = 1'b0;
        mul_mcand_next    = mul_mcand_reg;
        mul_mplier_next   = mul_mplier_reg;
        div_start_next    = 1'b0;
        div_dividend_next = div_dividend_reg;
        div_divisor_next  = div_divisor_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;
        kv_start          = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FULL_SCALE: full_scale_next = cfg_data[FS_W-1:0];
                REG_OUT_OHM:    out_ohm_next    = cfg_data[OHM_W-1:0];
                REG_FULL_OHM:   full_ohm_next   = cfg_data[OHM_W-1:0];
                REG_THR_COUNT:  thr_count_next  = cfg_data[THR_CNT_W-1:0];
                REG_THR_LO:     thr_lo_next     = cfg_data;
                REG_THR_HI:     thr_hi_next     = cfg_data;
                default:        ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    failed_next = !in_data.read_ok;
                    if (in_data.read_ok)
                    begin
                        mul_start_next  = 1'b1;
                        mul_mcand_next  = MCAND_W'(full_scale_reg);
                        mul_mplier_next = MPLIER_W'(in_data.adc_sample);
                        state_next      = ST_MUL_PIN;
                    end
                    else
                    begin
                        kv_start = 1'b1;
                    end
                end
            end
            ST_MUL_PIN:
            begin
                if (mul_done)
                begin
                    mul_start_next  = 1'b1;
                    mul_mcand_next  = full_ohm_reg;
                    mul_mplier_next = mul_product[ADC_BITS +: MPLIER_W];
                    state_next      = ST_MUL_SCALE;
                end
            end
            ST_MUL_SCALE:
            begin
                if (mul_done)
                begin
                    // A quotient of 65536 or more saturates, which covers a
                    // zero output resistance as well.
                    if (mul_product[PROD_W-1:QUO_W] >= out_ohm_reg)
                    begin
                        held_mv_next = MV_MAX;
                        state_next   = ST_PCT_CHK;
                    end
                    else
                    begin
                        div_start_next    = 1'b1;
                        div_dividend_next = mul_product;
                        div_divisor_next  = out_ohm_reg;
                        state_next        = ST_DIV_MV;
                    end
                end
            end
            ST_DIV_MV:
            begin
                if (div_done)
                begin
                    held_mv_next = div_quotient[MV_W-1:0];
                    state_next   = ST_PCT_CHK;
                end
            end
            ST_PCT_CHK:
            begin
                if (held_mv_reg <= thr_first)
                begin
                    held_pct_next = PCT_NONE;
                    kv_start      = 1'b1;
                end
                else if (held_mv_reg >= thr_last)
                begin
                    held_pct_next = PCT_FULL;
                    kv_start      = 1'b1;
                end
                else
                begin
                    idx_next   = THR_IDX_W'(1);
                    state_next = ST_PCT_SRCH;
                end
            end
            ST_PCT_SRCH:
            begin
                // The first segment whose upper threshold reaches the voltage
                // wins; the voltage is then strictly above its lower threshold.
                if (held_mv_reg <= thr_cur)
                begin
                    mul_start_next  = 1'b1;
                    mul_mcand_next  = MCAND_W'(held_mv_reg - thr_prev);
                    mul_mplier_next = MPLIER_W'(pct_hi - pct_lo);
                    lo_pct_next     = pct_lo;
                    width_next      = thr_cur - thr_prev;
                    state_next      = ST_MUL_PCT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MUL_PCT:
            begin
                if (mul_done)
                begin
                    div_start_next    = 1'b1;
                    div_dividend_next = mul_product;
                    div_divisor_next  = DIVISOR_W'(width_reg);
                    state_next        = ST_DIV_PCT;
                end
            end
            ST_DIV_PCT:
            begin
                if (div_done)
                begin
                    held_pct_next = lo_pct_reg + div_quotient[PCT_W-1:0];
                    kv_start      = 1'b1;
                end
            end
            ST_DIV_KV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.battery_mv     = held_mv_reg;
                    out_data_next.charge_percent = held_pct_reg;
                    out_data_next.volts_whole    = div_quotient[VOLTS_W-1:0];
                    out_data_next.volts_micro    = (kv_rem_w << 10) - (kv_rem_w << 4)
                                                   - (kv_rem_w << 3);
                    out_data_next.read_failed    = failed_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Split the final millivolts into whole volts and remainder.
        if (kv_start)
        begin
            div_start_next    = 1'b1;
            div_dividend_next = PROD_W'(held_mv_reg);
            div_divisor_next  = DIVISOR_W'(MV_PER_V);
            state_next        = ST_DIV_KV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            full_scale_reg <= FS_RESET;
            out_ohm_reg    <= OHM_RESET;
            full_ohm_reg   <= OHM_RESET;
            thr_count_reg  <= THR_CNT_RESET;
            thr_lo_reg     <= THR_LO_RESET;
            thr_hi_reg     <= THR_HI_RESET;
            held_mv_reg    <= '0;
            held_pct_reg   <= '0;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            full_scale_reg <= full_scale_next;
            out_ohm_reg    <= out_ohm_next;
            full_ohm_reg   <= full_ohm_next;
            thr_count_reg  <= thr_count_next;
            thr_lo_reg     <= thr_lo_next;
            thr_hi_reg     <= thr_hi_next;
            held_mv_reg    <= held_mv_next;
            held_pct_reg   <= held_pct_next;
            mul_start_reg  <= mul_start_next;
            div_start_reg  <= div_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        failed_reg       <= failed_next;
        idx_reg          <= idx_next;
        lo_pct_reg       <= lo_pct_next;
        width_reg        <= width_next;
        mul_mcand_reg    <= mul_mcand_next;
        mul_mplier_reg   <= mul_mplier_next;
        div_dividend_reg <= div_dividend_next;
        div_divisor_reg  <= div_divisor_next;
        out_data_reg     <= out_data_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sv/bsfa_checker.sv -----
// Port-level checks for the battery charge estimator, bound to the top level.
// Depends on bsfa_pkg for the result word type.
module bsfa_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  bsfa_pkg::out_word_t out_data
);
    import bsfa_pkg::*;

    // A stalled result word must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // One word at a time: the block is busy right after taking a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word was in flight");

    // Volts fields agree with the millivolt field.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_data.volts_whole) == 32'(out_data.battery_mv) / MV_PER_V)
            && (32'(out_data.volts_micro) == (32'(out_data.battery_mv) % MV_PER_V) * MV_PER_V)
            && (out_data.charge_percent <= PCT_FULL))
        else $error("result fields inconsistent");

    // Zero millivolts is always at or below the first threshold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.battery_mv == '0) |-> out_data.charge_percent == PCT_NONE)
        else $error("nonzero charge at zero volts");

endmodule

bind battery_soc_from_adc bsfa_checker u_bsfa_checker (.*);
